@@ src/lpss_pkg.sv @@
// shared constants and helpers for the length-prefixed suffix scanner
package lpss_pkg;

  localparam int RING_DEPTH_DEF = 260;
  localparam int SUF_LEN        = 5;
  localparam int PL_W           = 9;
  localparam int OFS_W          = 32;

  typedef logic [7:0] byte_t;

  // '.', 'm', 'a', 't', nul
  function automatic byte_t suffix_byte(input logic [2:0] idx);
    byte_t b;
    case (idx)
      3'd0:    b = 8'h2E;
      3'd1:    b = 8'h6D;
      3'd2:    b = 8'h61;
      3'd3:    b = 8'h74;
      3'd4:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ src/length_prefixed_suffix_scanner.sv @@
// top level of the length-prefixed suffix scanner
//
// in_* carries one byte per beat with in_group_start marking the first byte
// of a group; group start clears the history, match progress and offset.
// out_* carries one beat per found path: its length without the nul and the
// group offset of its first byte. Both channels use valid/ready.
// Bytes go into a ring memory of RING_DEPTH entries. While no '.mat'+nul
// suffix completes, one byte is accepted every cycle. A completed suffix
// starts a backward walk over the ring, one memory read per cycle through
// the single read port, testing one candidate size per cycle. With no
// fitting prefix in_ready stays low until every candidate size is tested.
// A hit of size s (nul included) ends the walk and keeps in_ready low until
// the push state has moved the result into the output register.
// The output register holds a waiting result while the next bytes are
// taken; only a second hit waits for the receiver, holding in_ready low.
// Reset clears all control state; the ring needs no clearing, entries from
// earlier groups are masked using the count of bytes held.
module length_prefixed_suffix_scanner
  import lpss_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_group_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PL_W-1:0]  out_path_length,
  output logic [OFS_W-1:0] out_path_start_offset
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int HW = $clog2(RING_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_PUSH   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [HW-1:0]    held_r, held_nxt;
  logic [2:0]       mp_r, mp_nxt;
  logic [OFS_W-1:0] go_r, go_nxt;
  logic [OFS_W-1:0] mo_r, mo_nxt;

  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic             iss_r, iss_nxt;
  logic             dv_r, dv_nxt;
  logic [AW-1:0]    dk_r, dk_nxt;
  byte_t            prev_r, prev_nxt;

  logic [PL_W-1:0]  hit_len_r, hit_len_nxt;
  logic [OFS_W-1:0] hit_ofs_r, hit_ofs_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PL_W-1:0]  out_len_r, out_len_nxt;
  logic [OFS_W-1:0] out_ofs_r, out_ofs_nxt;

  logic             acc;
  logic [AW-1:0]    wp_eff;
  logic [HW-1:0]    held_eff;
  logic [2:0]       mp_eff;
  logic [OFS_W-1:0] go_eff;
  logic             rd_en;
  byte_t            rd_data;
  byte_t            cur;
  logic [15:0]      s16;
  logic [15:0]      plen16;
  logic             hit;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  assign wp_eff   = in_group_start ? '0 : wp_r;
  assign held_eff = in_group_start ? '0 : held_r;
  assign mp_eff   = in_group_start ? '0 : mp_r;
  assign go_eff   = in_group_start ? '0 : go_r;

  assign rd_en = (state_r == ST_SEARCH) && iss_r;

  lpss_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (acc),
    .wr_addr(wp_eff),
    .wr_data(in_data_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr_r),
    .rd_data(rd_data)
  );

  // bytes outside the current group read as zero
  assign cur    = (HW'(dk_r) < held_r) ? rd_data : 8'h00;
  assign s16    = 16'(dk_r) - 16'd1;
  assign plen16 = s16 - 16'd1;
  assign hit    = dv_r && (dk_r > AW'(SUF_LEN)) && ({prev_r, cur} == s16);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    mp_nxt        = mp_r;
    go_nxt        = go_r;
    mo_nxt        = mo_r;
    rd_addr_nxt   = rd_addr_r;
    k_nxt         = k_r;
    iss_nxt       = iss_r;
    dv_nxt        = 1'b0;
    dk_nxt        = dk_r;
    prev_nxt      = prev_r;
    hit_len_nxt   = hit_len_r;
    hit_ofs_nxt   = hit_ofs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_len_nxt   = out_len_r;
    out_ofs_nxt   = out_ofs_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          wp_nxt   = (wp_eff == AW'(RING_DEPTH - 1)) ? '0 : wp_eff + 1'b1;
          held_nxt = (held_eff < HW'(RING_DEPTH)) ? held_eff + 1'b1 : held_eff;
          go_nxt   = go_eff + 1'b1;
          mo_nxt   = go_eff;
          mp_nxt   = '0;
          if (in_data_byte == suffix_byte(mp_eff)) begin
            if (mp_eff == 3'(SUF_LEN - 1)) begin
              state_nxt   = ST_SEARCH;
              iss_nxt     = 1'b1;
              k_nxt       = AW'(SUF_LEN);
              rd_addr_nxt = (wp_eff >= AW'(SUF_LEN)) ? wp_eff - AW'(SUF_LEN)
                                                     : wp_eff + AW'(RING_DEPTH - SUF_LEN);
            end else begin
              mp_nxt = mp_eff + 1'b1;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (iss_r) begin
          dv_nxt      = 1'b1;
          dk_nxt      = k_r;
          k_nxt       = k_r + 1'b1;
          rd_addr_nxt = (rd_addr_r == '0) ? AW'(RING_DEPTH - 1) : rd_addr_r - 1'b1;
          if (k_r == AW'(RING_DEPTH - 1)) begin
            iss_nxt = 1'b0;
          end
        end
        if (dv_r) begin
          prev_nxt = cur;
        end
        if (hit) begin
          hit_len_nxt = plen16[PL_W-1:0];
          hit_ofs_nxt = mo_r - OFS_W'(plen16);
          state_nxt   = ST_PUSH;
          iss_nxt     = 1'b0;
          dv_nxt      = 1'b0;
        end else if (dv_r && dk_r == AW'(RING_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
          iss_nxt   = 1'b0;
          dv_nxt    = 1'b0;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = hit_len_r;
          out_ofs_nxt   = hit_ofs_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      held_r      <= '0;
      mp_r        <= '0;
      go_r        <= '0;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      mp_r        <= mp_nxt;
      go_r        <= go_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mo_r      <= mo_nxt;
    rd_addr_r <= rd_addr_nxt;
    k_r       <= k_nxt;
    dk_r      <= dk_nxt;
    prev_r    <= prev_nxt;
    hit_len_r <= hit_len_nxt;
    hit_ofs_r <= hit_ofs_nxt;
    out_len_r <= out_len_nxt;
    out_ofs_r <= out_ofs_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_path_length       = out_len_r;
  assign out_path_start_offset = out_ofs_r;

  a_mp_range: assert property (@(posedge clk) disable iff (!rst_n)
    mp_r < 3'(SUF_LEN))
    else $error("match progress out of range");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(RING_DEPTH))
    else $error("bytes held beyond ring depth");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == ST_SEARCH) && (dk_r >= AW'(SUF_LEN)))
    else $error("ring read outside the length walk");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) && out_valid_r && !out_ready |=> (state_r == ST_PUSH))
    else $error("pending hit dropped while output stalled");

endmodule

@@ src/lpss_ram.sv @@
// generic single-write, single-read ram with registered read data
module lpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 260
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/length_prefixed_suffix_scanner_tb.sv @@
// self-checking testbench for the length-prefixed suffix scanner with valid/ready stimulus
module length_prefixed_suffix_scanner_tb
  import lpss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = RING_DEPTH_DEF;
  localparam logic [7:0] SUFFIX [SUF_LEN] = '{8'h2E, 8'h6D, 8'h61, 8'h74, 8'h00};
  localparam int TOTAL_BEATS = 1400;
  localparam int MIN_RECORDS = 16;
  localparam int HOLD_CYCLES = 500;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } scan_beat_t;

  typedef struct packed {
    logic [PL_W-1:0]  len;
    logic [OFS_W-1:0] ofs;
  } path_hit_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_group_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PL_W-1:0]  out_path_length;
  logic [OFS_W-1:0] out_path_start_offset;

  scan_beat_t beat_q[$];
  path_hit_t  path_q[$];
  path_hit_t  want;

  // scanner state as the block should hold it
  logic [7:0]  hist [RING_DEPTH];
  int unsigned wr_pos = 0;
  int unsigned suffix_pos = 0;
  int unsigned held = 0;
  logic [31:0] grp_ofs = '0;

  int queued_beats = 0;
  int records = 0;
  int beats_taken = 0;
  int groups_taken = 0;
  int hits_seen = 0;
  int longest = 0;
  int errors = 0;
  int in_gap = 0;
  int in_calm = 0;
  int rdy_stall = 0;
  int out_calm = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  length_prefixed_suffix_scanner dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_group_start       (in_group_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_path_length      (out_path_length),
    .out_path_start_offset(out_path_start_offset)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] hist_back(input int unsigned k);
    if (k >= held || k >= RING_DEPTH) return 8'h00;
    return hist[(wr_pos + RING_DEPTH - k) % RING_DEPTH];
  endfunction

  task automatic track_beat(input logic [7:0] d, input logic s);
    path_hit_t hit;
    bit found;
    found = 1'b0;
    if (s) begin
      wr_pos = 0;
      suffix_pos = 0;
      held = 0;
      grp_ofs = '0;
    end
    hist[wr_pos] = d;
    if (held < RING_DEPTH) held++;
    if (d == SUFFIX[suffix_pos]) begin
      suffix_pos++;
      if (suffix_pos == SUF_LEN) begin
        for (int unsigned sz = 5; sz <= RING_DEPTH - 2; sz++) begin
          if (!found && {hist_back(sz), hist_back(sz + 1)} == sz) begin
            found = 1'b1;
            hit.len = PL_W'(sz - 1);
            hit.ofs = grp_ofs - OFS_W'(sz - 1);
            path_q.push_back(hit);
          end
        end
        suffix_pos = 0;
      end
    end else begin
      suffix_pos = 0;
    end
    wr_pos = (wr_pos + 1) % RING_DEPTH;
    grp_ofs = grp_ofs + 1;
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_beat(input logic [7:0] d, input logic s);
    scan_beat_t bt;
    bt.data = d;
    bt.start = s;
    beat_q.push_back(bt);
    queued_beats++;
  endtask

  task automatic add_suffix(input int bad_at);
    for (int i = 0; i < SUF_LEN; i++) begin
      add_beat((i == bad_at) ? (SUFFIX[i] ^ 8'h01) : SUFFIX[i], 1'b0);
    end
  endtask

  // prefix, body of size-5 bytes, then the suffix
  task automatic add_path(input int size, input int prefix, input bit s, input int fill,
                          input int bad_at);
    logic [7:0] b;
    add_beat(prefix[7:0], s);
    add_beat(prefix[15:8], 1'b0);
    for (int i = 0; i < size - SUF_LEN; i++) begin
      if (fill >= 0) b = fill[7:0];
      else if ($urandom_range(0, 5) == 0) b = SUFFIX[$urandom_range(0, SUF_LEN - 1)];
      else b = 8'($urandom_range(0, 255));
      add_beat(b, 1'b0);
    end
    add_suffix(bad_at);
  endtask

  // driver
  always @(posedge clk) begin
    scan_beat_t bt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        track_beat(in_data_byte, in_group_start);
        beats_taken++;
        if (in_group_start) groups_taken++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        bt = beat_q.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= bt.data;
        in_group_start <= bt.start;
        in_gap = idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    int len;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        hits_seen++;
        if (out_path_length > longest) longest = out_path_length;
        if (path_q.size() == 0) begin
          $display("%0t: unexpected path beat, length %0d offset %0d", $time,
                   out_path_length, out_path_start_offset);
          errors++;
        end else begin
          want = path_q.pop_front();
          if (out_path_length !== want.len) begin
            $display("%0t: path_length expected %0d got %0d", $time, want.len,
                     out_path_length);
            errors++;
          end
          if (out_path_start_offset !== want.ofs) begin
            $display("%0t: path_start_offset expected %0d got %0d", $time, want.ofs,
                     out_path_start_offset);
            errors++;
          end
        end
      end
      if (!hold_done && hits_seen >= 8) begin
        // long hold-off so the block backs up into its input
        hold_done = 1'b1;
        rdy_stall = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rdy_stall > 0) begin
        rdy_stall--;
        out_ready <= 1'b0;
      end else begin
        len = idle_len(out_calm);
        if (len == 0) begin
          out_ready <= 1'b1;
        end else begin
          rdy_stall = len - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d paths still due", $time,
                 idle_cycles, path_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int sz;

    // stream taken as one group from reset
    add_path(5, 5, 1'b0, -1, -1);
    // repeated dot drops the match even though the prefix fits
    add_beat(8'h06, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h2E, 1'b0);
    add_suffix(-1);
    // suffix without a fitting prefix
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_suffix(-1);
    // group start in the middle of the suffix
    add_beat(8'h07, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h2E, 1'b0);
    add_beat(8'h6D, 1'b0);
    add_beat(8'h61, 1'b0);
    add_beat(8'h74, 1'b1);
    add_beat(8'h00, 1'b0);
    // prefix low byte lies before the group and reads as zero
    add_beat(8'h01, 1'b1);
    repeat (251) add_beat(8'h41, 1'b0);
    add_suffix(-1);
    // largest size and one past it
    add_path(RING_DEPTH - 2, RING_DEPTH - 2, 1'b1, 8'hFF, -1);
    add_path(RING_DEPTH - 1, RING_DEPTH - 1, 1'b1, 8'hFF, -1);
    // all-zero and all-one bodies
    add_path(9, 9, 1'b1, 8'h00, -1);
    add_path(12, 12, 1'b0, 8'hFF, -1);

    while (queued_beats < TOTAL_BEATS || records < MIN_RECORDS) begin
      pick = $urandom_range(0, 19);
      sz = ($urandom_range(0, 14) == 0) ? $urandom_range(25, RING_DEPTH - 2)
                                        : $urandom_range(5, 24);
      if (pick < 13) begin
        add_path(sz, sz, ($urandom_range(0, 3) == 0), -1, -1);
        records++;
      end else if (pick < 15) begin
        repeat ($urandom_range(1, 8)) add_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 17) begin
        if ($urandom_range(0, 1) == 0)
          add_path(sz, sz + $urandom_range(1, 3), 1'b0, -1, -1);
        else
          add_path(sz, sz, 1'b0, -1, $urandom_range(0, SUF_LEN - 1));
      end else if (pick < 19) begin
        add_beat(8'h2E, 1'b0);
        if ($urandom_range(0, 1) == 0) add_beat(8'h2E, 1'b0);
        add_beat(8'h6D, 1'b0);
        add_beat(8'h61, 1'b0);
        add_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_beat(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || in_valid) @(posedge clk);
    while (path_q.size() != 0) @(posedge clk);
    repeat (RING_DEPTH + 20) @(posedge clk);

    $display("scanned %0d bytes over %0d group starts, %0d well-formed records",
             beats_taken, groups_taken, records);
    $display("%0d paths reported, longest %0d bytes, %0d mismatches",
             hits_seen, longest, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lpss_pkg.sv
src/lpss_ram.sv
src/length_prefixed_suffix_scanner.sv
tb/length_prefixed_suffix_scanner_tb.sv
